// ===== sv/i2cs_pkg.sv =====
// Shared types and constants for the I2C transfer command sequencer.
package i2cs_pkg;

  // Command FIFO depth of the controller (2 to 256) and length field width (4 to 24)
  localparam int CMD_FIFO_DEPTH = 16;
  localparam int LENGTH_BITS    = 16;

  // Length fields are 16 bits wide, so at most 16 bits of the mask matter
  localparam int LEN_EFF = (LENGTH_BITS < 16) ? LENGTH_BITS : 16;
  localparam logic [15:0] LEN_MASK = 16'((17'd1 << LEN_EFF) - 17'd1);
  localparam logic [8:0]  FIFO_DEPTH_W = 9'(CMD_FIFO_DEPTH);

  // Command word flag bits
  localparam logic [11:0] CMD_READ      = 12'h100;
  localparam logic [11:0] CMD_RESTART   = 12'h200;
  localparam logic [11:0] CMD_STOP      = 12'h400;
  localparam logic [11:0] CMD_NACK_LAST = 12'h800;
  localparam logic [10:0] TEN_BIT_FLAG  = 11'h400;
  localparam logic [9:0]  ADDR7_MAX     = 10'h07F;

  // Transfer status codes
  typedef enum logic [2:0] {
    ST_RUN     = 3'd0,
    ST_OK      = 3'd1,
    ST_INVALID = 3'd2,
    ST_IO      = 3'd3,
    ST_TIMEOUT = 3'd4
  } status_t;

  // Configuration register indexes
  typedef enum logic [2:0] {
    REG_TARGET_ADDRESS = 3'd0,
    REG_TEN_BIT_MODE   = 3'd1,
    REG_PREFIX_COUNT   = 3'd2,
    REG_WRITE_COUNT    = 3'd3,
    REG_READ_COUNT     = 3'd4,
    REG_POLL_LIMIT     = 3'd5
  } reg_index_t;

  // Item kinds
  localparam logic KIND_START = 1'b0;
  localparam logic KIND_POLL  = 1'b1;

  typedef struct packed {
    logic       kind;
    logic       error_seen;
    logic [7:0] cmd_fifo_level;
    logic [7:0] rx_fifo_level;
    logic [7:0] rx_byte_in;
    logic       done_seen;
    logic [7:0] write_byte;
  } in_item_t;

  typedef struct packed {
    status_t     status;
    logic [10:0] target_word;
    logic        push_command;
    logic [11:0] command_word;
    logic [16:0] cmd_position;
    logic        pop_rx;
    logic [7:0]  rx_byte_out;
    logic [15:0] rx_position;
    logic        clear_done;
    logic        abort_request;
  } out_item_t;

endpackage

// ===== sv/i2c_transfer_command_sequencer.sv =====
// Top level of the I2C transfer command sequencer.
//
// Usage: program the target address, addressing mode, prefix, write and read
// counts and the poll budget over the APB port while no item is in flight.
// Each item on the input channel is either a start (checks the setup and gives
// the target word) or a poll (one sample of the controller's FIFO and flag
// status). Every item yields exactly one result item: push at most one
// command word, pop at most one received byte, and report the final status.
// The result of an item is registered: an item accepted at one edge gives a
// result that is valid after that edge, held in the output register. One item
// per cycle is taken while out_stall does not hold an untaken result; the single
// result register sets this, since all decisions and counter updates are combinational.
// While the output register holds an untaken result, in_stall follows
// out_stall; an item is taken in the same cycle as the result leaves.
// Reset (synchronous, rst high) clears all configuration registers, the
// transfer state and the output valid; no item is in flight afterwards.
module i2c_transfer_command_sequencer (
  input  logic                clk,
  input  logic                rst,
  // input channel
  input  logic                in_valid,
  output logic                in_stall,
  input  i2cs_pkg::in_item_t  in_item,
  // result channel
  output logic                out_valid,
  input  logic                out_stall,
  output i2cs_pkg::out_item_t out_item,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [4:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import i2cs_pkg::*;

  // configuration registers
  logic [9:0]  target_address;
  logic        ten_bit_mode;
  logic [1:0]  prefix_count;
  logic [15:0] write_count;
  logic [15:0] read_count;
  logic [31:0] poll_limit;

  // transfer state
  logic        active, active_next;
  status_t     last_status, last_status_next;
  logic [17:0] commands_sent, commands_sent_next;
  logic [15:0] bytes_received, bytes_received_next;
  logic [31:0] polls_left, polls_left_next;

  logic        in_acc;
  logic        cfg_wr;
  reg_index_t  cfg_idx;
  out_item_t   out_next;

  // derived lengths
  logic [15:0] wlen_pay, rlen;
  logic [17:0] wlen, total;
  logic        addr_ok;
  logic        can_push, can_pop, all_met;
  logic [17:0] sent_plus1;
  logic [15:0] recv_plus1;
  logic [11:0] cmd_word;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign cfg_idx  = reg_index_t'(paddr[4:2]);
  assign in_stall = out_valid && out_stall;
  assign in_acc   = in_valid && !in_stall;

  // configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      target_address <= '0;
      ten_bit_mode   <= 1'b0;
      prefix_count   <= '0;
      write_count    <= '0;
      read_count     <= '0;
      poll_limit     <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx)
        REG_TARGET_ADDRESS: target_address <= pwdata[9:0];
        REG_TEN_BIT_MODE:   ten_bit_mode   <= pwdata[0];
        REG_PREFIX_COUNT:   prefix_count   <= pwdata[1:0];
        REG_WRITE_COUNT:    write_count    <= pwdata[15:0];
        REG_READ_COUNT:     read_count     <= pwdata[15:0];
        REG_POLL_LIMIT:     poll_limit     <= pwdata;
        default: ;
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (cfg_idx)
      REG_TARGET_ADDRESS: prdata = {22'd0, target_address};
      REG_TEN_BIT_MODE:   prdata = {31'd0, ten_bit_mode};
      REG_PREFIX_COUNT:   prdata = {30'd0, prefix_count};
      REG_WRITE_COUNT:    prdata = {16'd0, write_count};
      REG_READ_COUNT:     prdata = {16'd0, read_count};
      REG_POLL_LIMIT:     prdata = poll_limit;
      default:            prdata = '0;
    endcase
  end

  // lengths and checks
  assign wlen_pay   = write_count & LEN_MASK;
  assign rlen       = read_count & LEN_MASK;
  assign wlen       = {16'd0, prefix_count} + {2'd0, wlen_pay};
  assign total      = wlen + {2'd0, rlen};
  assign addr_ok    = ten_bit_mode || (target_address <= ADDR7_MAX);
  assign sent_plus1 = commands_sent + 18'd1;
  assign recv_plus1 = bytes_received + 16'd1;
  assign can_push   = (commands_sent < total) &&
                      ({1'b0, in_item.cmd_fifo_level} < FIFO_DEPTH_W);
  assign can_pop    = (bytes_received < rlen) && (in_item.rx_fifo_level != 8'd0);

  // command word for the current index
  always_comb begin
    if (commands_sent < wlen) begin
      cmd_word = {4'd0, in_item.write_byte};
    end else begin
      cmd_word = CMD_READ;
      if (commands_sent == wlen && wlen != 18'd0) cmd_word = cmd_word | CMD_RESTART;
    end
    if (sent_plus1 == total) begin
      cmd_word = cmd_word | CMD_STOP;
      if (commands_sent >= wlen) cmd_word = cmd_word | CMD_NACK_LAST;
    end
  end

  // counts after this poll's push and pop
  assign all_met = (can_push ? (sent_plus1 == total) : (commands_sent == total)) &&
                   (can_pop ? (recv_plus1 == rlen) : (bytes_received == rlen));

  // per-item decision
  always_comb begin
    out_next            = '0;
    out_next.status     = ST_RUN;
    active_next         = active;
    last_status_next    = last_status;
    commands_sent_next  = commands_sent;
    bytes_received_next = bytes_received;
    polls_left_next     = polls_left;
    priority if (in_item.kind == KIND_START) begin
      if (total == 18'd0 || !addr_ok || prefix_count > 2'd2) begin
        out_next.status  = ST_INVALID;
        active_next      = 1'b0;
        last_status_next = ST_INVALID;
      end else begin
        out_next.target_word = {1'b0, target_address} | (ten_bit_mode ? TEN_BIT_FLAG : 11'd0);
        active_next          = 1'b1;
        last_status_next     = ST_RUN;
        commands_sent_next   = '0;
        bytes_received_next  = '0;
        polls_left_next      = poll_limit;
      end
    end else if (!active) begin
      out_next.status = last_status;
    end else if (polls_left == 32'd0) begin
      out_next.status        = ST_TIMEOUT;
      out_next.abort_request = 1'b1;
      active_next            = 1'b0;
      last_status_next       = ST_TIMEOUT;
    end else if (in_item.error_seen) begin
      out_next.status  = ST_IO;
      active_next      = 1'b0;
      last_status_next = ST_IO;
    end else begin
      if (can_push) begin
        out_next.push_command = 1'b1;
        out_next.command_word = cmd_word;
        out_next.cmd_position = commands_sent[16:0];
        commands_sent_next    = sent_plus1;
      end
      if (can_pop) begin
        out_next.pop_rx      = 1'b1;
        out_next.rx_byte_out = in_item.rx_byte_in;
        out_next.rx_position = bytes_received;
        bytes_received_next  = recv_plus1;
      end
      if (in_item.done_seen && all_met) begin
        out_next.clear_done = 1'b1;
        out_next.status     = ST_OK;
        active_next         = 1'b0;
        last_status_next    = ST_OK;
      end else begin
        polls_left_next = polls_left - 32'd1;
      end
    end
  end

  // state and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      active         <= 1'b0;
      last_status    <= ST_RUN;
      commands_sent  <= '0;
      bytes_received <= '0;
      polls_left     <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (in_acc) begin
        active         <= active_next;
        last_status    <= last_status_next;
        commands_sent  <= commands_sent_next;
        bytes_received <= bytes_received_next;
        polls_left     <= polls_left_next;
        out_valid      <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) out_item <= out_next;
  end

`ifndef SYNTHESIS
  // a good start leaves the transfer running
  a_start_active: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_item.kind == KIND_START && out_next.status == ST_RUN |=> active)
    else $error("start did not activate transfer");

  // abort only comes with a timeout
  a_abort_timeout: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.abort_request |-> out_item.status == ST_TIMEOUT)
    else $error("abort without timeout");

  // done is acknowledged only on success
  a_clear_ok: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_item.clear_done |-> out_item.status == ST_OK)
    else $error("clear_done without ok status");

  // command fields are zero when nothing is pushed
  a_push_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_item.push_command |->
      out_item.command_word == 12'd0 && out_item.cmd_position == 17'd0)
    else $error("command fields set without push");

  // an idle sequencer keeps its counters on polls
  a_idle_hold: assert property (@(posedge clk) disable iff (rst)
    in_acc && in_item.kind == KIND_POLL && !active |=> $stable(commands_sent) && !active)
    else $error("idle poll changed state");
`endif

endmodule

// ===== tb/i2c_transfer_command_sequencer_tb.sv =====
// Testbench for the I2C transfer command sequencer: directed table, random transfers, checker.
`timescale 1ns / 100ps

module i2c_transfer_command_sequencer_tb;
  import i2cs_pkg::*;

  localparam int STALL_LIMIT = 2000;

  // DUT connections
  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic        in_stall;
  in_item_t    in_item   = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        psel      = 1'b0;
  logic        penable   = 1'b0;
  logic        pwrite    = 1'b0;
  logic [4:0]  paddr     = '0;
  logic [31:0] pwdata    = '0;
  logic [31:0] prdata;
  logic        pready;

  // Idle rates in percent
  int tx_idle_pct = 12;
  int rx_idle_pct = 85;

  int err_cnt     = 0;
  int stuck_cycles = 0;

  // Results predicted for accepted items, oldest first
  out_item_t pending_results[$];

  // Hand-typed expectation for the item now on the input channel
  bit        use_typed = 1'b0;
  out_item_t typed_exp = '0;

  // Shadow configuration
  logic [9:0]  cfg_addr   = '0;
  logic        cfg_ten    = 1'b0;
  logic [1:0]  cfg_prefix = '0;
  logic [15:0] cfg_wcnt   = '0;
  logic [15:0] cfg_rcnt   = '0;
  logic [31:0] cfg_plimit = '0;

  // Shadow transfer state
  logic        st_active = 1'b0;
  status_t     st_last   = ST_RUN;
  int unsigned st_sent   = 0;
  int unsigned st_rcvd   = 0;
  logic [31:0] st_polls  = '0;

  // Directed stimulus table
  typedef struct {
    bit         is_cfg;
    reg_index_t idx;
    logic [31:0] val;
    in_item_t   item;
    bit         typed;
    out_item_t  exp;
  } dir_row_t;

  dir_row_t dir_tab[$];

  i2c_transfer_command_sequencer uut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Receiver stalls at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < rx_idle_pct);
  end

  // Command word for position idx of the transfer
  function automatic logic [11:0] command_for(int unsigned idx, logic [7:0] data);
    int unsigned wlen;
    int unsigned tot;
    logic [11:0] w;
    wlen = 32'(cfg_prefix) + 32'(cfg_wcnt & LEN_MASK);
    tot  = wlen + 32'(cfg_rcnt & LEN_MASK);
    if (idx < wlen) begin
      w = {4'h0, data};
    end else begin
      w = CMD_READ;
      // restart on the first read after writes
      if (idx == wlen && wlen != 0) w = w | CMD_RESTART;
    end
    if (idx + 1 == tot) begin
      w = w | CMD_STOP;
      if (idx >= wlen) w = w | CMD_NACK_LAST;
    end
    return w;
  endfunction

  // One step of the sequencer: returns the result and advances the shadow state
  function automatic out_item_t step_sequencer(in_item_t it);
    out_item_t   r;
    int unsigned tot;
    int unsigned rlen;
    logic        addr_ok;
    r        = '0;
    r.status = ST_RUN;
    rlen     = 32'(cfg_rcnt & LEN_MASK);
    tot      = 32'(cfg_prefix) + 32'(cfg_wcnt & LEN_MASK) + rlen;
    if (it.kind == KIND_START) begin
      addr_ok = cfg_ten ? 1'b1 : (cfg_addr <= ADDR7_MAX);
      if (tot == 0 || !addr_ok || cfg_prefix > 2'd2) begin
        r.status  = ST_INVALID;
        st_active = 1'b0;
        st_last   = ST_INVALID;
      end else begin
        r.target_word = {1'b0, cfg_addr} | (cfg_ten ? TEN_BIT_FLAG : 11'h000);
        st_active = 1'b1;
        st_last   = ST_RUN;
        st_sent   = 0;
        st_rcvd   = 0;
        st_polls  = cfg_plimit;
      end
    end else if (!st_active) begin
      r.status = st_last;
    end else if (st_polls == 0) begin
      r.status        = ST_TIMEOUT;
      r.abort_request = 1'b1;
      st_active       = 1'b0;
      st_last         = ST_TIMEOUT;
    end else if (it.error_seen) begin
      r.status  = ST_IO;
      st_active = 1'b0;
      st_last   = ST_IO;
    end else begin
      // push one command while the FIFO has room
      if (st_sent < tot && int'(it.cmd_fifo_level) < CMD_FIFO_DEPTH) begin
        r.push_command = 1'b1;
        r.cmd_position = 17'(st_sent);
        r.command_word = command_for(st_sent, it.write_byte);
        st_sent++;
      end
      // pop one received byte
      if (st_rcvd < rlen && it.rx_fifo_level != 8'h00) begin
        r.pop_rx      = 1'b1;
        r.rx_byte_out = it.rx_byte_in;
        r.rx_position = 16'(st_rcvd);
        st_rcvd++;
      end
      if (it.done_seen && st_sent == tot && st_rcvd == rlen) begin
        r.clear_done = 1'b1;
        r.status     = ST_OK;
        st_active    = 1'b0;
        st_last      = ST_OK;
      end else begin
        st_polls = st_polls - 32'd1;
      end
    end
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
      err_cnt++;
    end
  endfunction

  // Checker, predictor hookup and watchdog
  always @(posedge clk) begin : monitor
    logic      fired;
    out_item_t want;
    out_item_t pred;
    if (!rst) begin
      fired = 1'b0;
      if (out_valid && !out_stall) begin
        fired = 1'b1;
        if (pending_results.size() == 0) begin
          $error("result item with no expectation waiting");
          err_cnt++;
        end else begin
          want = pending_results.pop_front();
          check_field("status", 32'(want.status), 32'(out_item.status));
          check_field("target_word", 32'(want.target_word), 32'(out_item.target_word));
          check_field("push_command", 32'(want.push_command), 32'(out_item.push_command));
          check_field("command_word", 32'(want.command_word), 32'(out_item.command_word));
          check_field("cmd_position", 32'(want.cmd_position),
                      32'(out_item.cmd_position));
          check_field("pop_rx", 32'(want.pop_rx), 32'(out_item.pop_rx));
          check_field("rx_byte_out", 32'(want.rx_byte_out), 32'(out_item.rx_byte_out));
          check_field("rx_position", 32'(want.rx_position), 32'(out_item.rx_position));
          check_field("clear_done", 32'(want.clear_done), 32'(out_item.clear_done));
          check_field("abort_request", 32'(want.abort_request),
                      32'(out_item.abort_request));
        end
      end
      if (in_valid && !in_stall) begin
        fired = 1'b1;
        pred  = step_sequencer(in_item);
        pending_results.push_back(use_typed ? typed_exp : pred);
      end
      if (psel && penable && pwrite && pready) fired = 1'b1;
      if (fired) stuck_cycles = 0;
      else stuck_cycles++;
      if (stuck_cycles >= STALL_LIMIT) begin
        $display("i2c_transfer_command_sequencer_tb: FAIL");
        $finish;
      end
    end
  end

  // Hold the sender off until every expected result has come
  task automatic drain_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // APB register write, only with nothing in flight
  task automatic cfg_write(reg_index_t idx, logic [31:0] val);
    drain_results();
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    case (idx)
      REG_TARGET_ADDRESS: cfg_addr   = val[9:0];
      REG_TEN_BIT_MODE:   cfg_ten    = val[0];
      REG_PREFIX_COUNT:   cfg_prefix = val[1:0];
      REG_WRITE_COUNT:    cfg_wcnt   = val[15:0];
      REG_READ_COUNT:     cfg_rcnt   = val[15:0];
      REG_POLL_LIMIT:     cfg_plimit = val;
      default: ;
    endcase
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // Offer one item, with random idle cycles ahead of it
  task automatic send_item(in_item_t it, bit typed, out_item_t texp);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    use_typed = typed;
    typed_exp = texp;
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!(in_valid && !in_stall));
    @(negedge clk);
    use_typed = 1'b0;
  endtask

  // Empty table row
  function automatic dir_row_t blank_row();
    dir_row_t r;
    r = '{is_cfg: 1'b0, idx: REG_TARGET_ADDRESS, val: '0, item: '0, typed: 1'b0, exp: '0};
    return r;
  endfunction

  function automatic dir_row_t cfg_row(reg_index_t idx, logic [31:0] val);
    dir_row_t r;
    r        = blank_row();
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.val    = val;
    return r;
  endfunction

  function automatic dir_row_t poll_row(logic err, logic [7:0] cmd_lvl, logic [7:0] rx_lvl,
                                        logic [7:0] rx_byte, logic done, logic [7:0] wbyte);
    dir_row_t r;
    r      = blank_row();
    r.item = '{kind: KIND_POLL, error_seen: err, cmd_fifo_level: cmd_lvl,
               rx_fifo_level: rx_lvl, rx_byte_in: rx_byte, done_seen: done,
               write_byte: wbyte};
    return r;
  endfunction

  function automatic dir_row_t start_row();
    dir_row_t r;
    r           = blank_row();
    r.item.kind = KIND_START;
    return r;
  endfunction

  // Attach a hand-typed result; unlisted fields are zero
  function automatic dir_row_t with_exp(dir_row_t r, status_t s, logic [10:0] tw, logic ab);
    r.typed             = 1'b1;
    r.exp               = '0;
    r.exp.status        = s;
    r.exp.target_word   = tw;
    r.exp.abort_request = ab;
    return r;
  endfunction

  function automatic in_item_t rand_item(logic kind);
    in_item_t it;
    it.kind           = kind;
    it.error_seen     = ($urandom_range(99) < 3);
    it.cmd_fifo_level = ($urandom_range(1) == 1) ? 8'($urandom_range(0, CMD_FIFO_DEPTH - 1))
                                                 : 8'($urandom_range(0, 255));
    it.rx_fifo_level  = ($urandom_range(1) == 1) ? 8'h00 : 8'($urandom_range(0, 255));
    it.rx_byte_in     = 8'($urandom_range(0, 255));
    it.done_seen      = ($urandom_range(99) < 35);
    it.write_byte     = 8'($urandom_range(0, 255));
    return it;
  endfunction

  // Mostly short lengths so transfers finish, now and then a long one
  function automatic logic [31:0] rand_len();
    return ($urandom_range(9) == 0) ? $urandom_range(0, 65535) : $urandom_range(0, 5);
  endfunction

  // New settings, then a run of transfers with random content
  task automatic run_phase(int n_items);
    int          counted;
    int          roll;
    logic [31:0] lim;
    cfg_write(REG_TARGET_ADDRESS,
              ($urandom_range(99) < 70) ? $urandom_range(0, 127) : $urandom_range(0, 1023));
    cfg_write(REG_TEN_BIT_MODE, $urandom_range(0, 1));
    cfg_write(REG_PREFIX_COUNT, ($urandom_range(9) == 0) ? 3 : $urandom_range(0, 2));
    cfg_write(REG_WRITE_COUNT, rand_len());
    cfg_write(REG_READ_COUNT, rand_len());
    roll = $urandom_range(99);
    if (roll < 30) lim = $urandom_range(0, 15);
    else if (roll < 95) lim = $urandom_range(40, 200);
    else lim = $urandom;
    cfg_write(REG_POLL_LIMIT, lim);
    counted = 0;
    while (counted < n_items) begin
      if ((!st_active && $urandom_range(1) == 1) || $urandom_range(99) < 3) begin
        send_item(rand_item(KIND_START), 1'b0, '0);
      end else begin
        send_item(rand_item(KIND_POLL), 1'b0, '0);
      end
      counted++;
      if ($urandom_range(99) < 2) drain_results();
    end
  endtask

  initial begin : main_seq
    int done_n;
    int n;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // after reset: idle poll, empty transfer, idle poll repeats the last status
    dir_tab.push_back(with_exp(poll_row(0, 8'h00, 8'h00, 8'h00, 0, 8'h00), ST_RUN, 11'h0, 0));
    dir_tab.push_back(with_exp(start_row(), ST_INVALID, 11'h0, 0));
    dir_tab.push_back(with_exp(poll_row(1, 8'hFF, 8'hFF, 8'hFF, 1, 8'hFF),
                               ST_INVALID, 11'h0, 0));
    // address above the 7-bit range
    dir_tab.push_back(cfg_row(REG_TARGET_ADDRESS, 32'h080));
    dir_tab.push_back(cfg_row(REG_WRITE_COUNT, 32'd1));
    dir_tab.push_back(cfg_row(REG_POLL_LIMIT, 32'hFFFF_FFFF));
    dir_tab.push_back(with_exp(start_row(), ST_INVALID, 11'h0, 0));
    // same address in 10-bit mode: one write byte, then done
    dir_tab.push_back(cfg_row(REG_TEN_BIT_MODE, 32'd1));
    dir_tab.push_back(with_exp(start_row(), ST_RUN, 11'h480, 0));
    dir_tab.push_back(poll_row(0, 8'h0F, 8'h00, 8'h00, 0, 8'hFF));
    dir_tab.push_back(poll_row(0, 8'h00, 8'h00, 8'h00, 1, 8'h00));
    // prefix count out of range
    dir_tab.push_back(cfg_row(REG_PREFIX_COUNT, 32'd3));
    dir_tab.push_back(with_exp(start_row(), ST_INVALID, 11'h0, 0));
    // zero budget: timeout wins over the error flag
    dir_tab.push_back(cfg_row(REG_PREFIX_COUNT, 32'd2));
    dir_tab.push_back(cfg_row(REG_WRITE_COUNT, 32'd0));
    dir_tab.push_back(cfg_row(REG_READ_COUNT, 32'd2));
    dir_tab.push_back(cfg_row(REG_TARGET_ADDRESS, 32'h3FF));
    dir_tab.push_back(cfg_row(REG_POLL_LIMIT, 32'd0));
    dir_tab.push_back(with_exp(start_row(), ST_RUN, 11'h7FF, 0));
    dir_tab.push_back(with_exp(poll_row(1, 8'h00, 8'h00, 8'h00, 1, 8'h00),
                               ST_TIMEOUT, 11'h0, 1));
    // prefix then reads: full FIFO, pops, restart, nack on last read
    dir_tab.push_back(cfg_row(REG_POLL_LIMIT, 32'd20));
    dir_tab.push_back(start_row());
    dir_tab.push_back(poll_row(0, 8'h10, 8'hFF, 8'hA5, 1, 8'h5A));
    dir_tab.push_back(poll_row(0, 8'hFF, 8'h00, 8'h00, 0, 8'h00));
    dir_tab.push_back(poll_row(0, 8'h00, 8'h00, 8'h00, 0, 8'h00));
    dir_tab.push_back(poll_row(0, 8'h0F, 8'h01, 8'h00, 0, 8'hFF));
    dir_tab.push_back(poll_row(0, 8'h00, 8'h00, 8'h00, 1, 8'h00));
    dir_tab.push_back(poll_row(0, 8'h00, 8'h00, 8'h00, 1, 8'h00));
    // start while active drops the running transfer; then an I/O error
    dir_tab.push_back(start_row());
    dir_tab.push_back(poll_row(0, 8'h00, 8'h00, 8'h00, 0, 8'h3C));
    dir_tab.push_back(start_row());
    dir_tab.push_back(with_exp(poll_row(1, 8'h00, 8'h01, 8'h55, 0, 8'hAA),
                               ST_IO, 11'h0, 0));
    // longest lengths, top 7-bit address, budget of one
    dir_tab.push_back(cfg_row(REG_TARGET_ADDRESS, 32'h07F));
    dir_tab.push_back(cfg_row(REG_TEN_BIT_MODE, 32'd0));
    dir_tab.push_back(cfg_row(REG_WRITE_COUNT, 32'd65535));
    dir_tab.push_back(cfg_row(REG_READ_COUNT, 32'd65535));
    dir_tab.push_back(cfg_row(REG_POLL_LIMIT, 32'd1));
    dir_tab.push_back(with_exp(start_row(), ST_RUN, 11'h07F, 0));
    dir_tab.push_back(poll_row(0, 8'h00, 8'h01, 8'h81, 0, 8'h77));
    dir_tab.push_back(with_exp(poll_row(0, 8'h00, 8'h00, 8'h00, 0, 8'h00),
                               ST_TIMEOUT, 11'h0, 1));
    dir_tab.push_back(with_exp(poll_row(0, 8'h00, 8'h00, 8'h00, 0, 8'h00),
                               ST_TIMEOUT, 11'h0, 0));

    foreach (dir_tab[i]) begin
      if (dir_tab[i].is_cfg) cfg_write(dir_tab[i].idx, dir_tab[i].val);
      else send_item(dir_tab[i].item, dir_tab[i].typed, dir_tab[i].exp);
    end

    // random part under three idle patterns
    for (int m = 0; m < 3; m++) begin
      case (m)
        0: begin tx_idle_pct = 12; rx_idle_pct = 85; end
        1: begin tx_idle_pct = 85; rx_idle_pct = 12; end
        default: begin tx_idle_pct = 0; rx_idle_pct = 0; end
      endcase
      done_n = 0;
      while (done_n < 667) begin
        n = $urandom_range(10, 50);
        run_phase(n);
        done_n += n;
      end
    end

    drain_results();
    repeat (4) @(negedge clk);
    if (err_cnt == 0) begin
      $display("i2c_transfer_command_sequencer_tb: PASS");
    end else begin
      $display("i2c_transfer_command_sequencer_tb: FAIL");
    end
    $finish;
  end

endmodule
